/* rtl/rcb_pkg.sv */
// Shared constants, register codes and types for the RGB 3x3 convolution blur.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rcb_pkg;

  localparam int MAX_COLS_DEF   = 1024;
  localparam int COEF_FRAC_DEF  = 12;

  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int COEF_W     = 16;
  localparam int KERNEL_W   = 3 * COEF_W;
  localparam int COLS_CFG_W = 11;
  localparam int ROWS_W     = 16;
  localparam int CNT_W      = 26;

  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMAGE_COLS    = 3'd0,
    REG_IMAGE_ROWS    = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MIDDLE = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4
  } reg_index_t;

  localparam logic [COLS_CFG_W-1:0] IMAGE_COLS_RESET = 11'd640;
  localparam logic [ROWS_W-1:0]     IMAGE_ROWS_RESET = 16'd480;
  // 455 in every Q4.12 position, roughly 1/9
  localparam logic [KERNEL_W-1:0]   KERNEL_RESET     = 48'd1954239939015;

  typedef logic [PIX_W-1:0] pixel_t;
  // index [row][col], row 0 is the row above, col 0 the left column
  typedef pixel_t [2:0][2:0] window_t;

  typedef struct packed {
    logic [COLS_CFG_W-1:0]        image_cols;
    logic [ROWS_W-1:0]            image_rows;
    logic [2:0][KERNEL_W-1:0]     kernel;
  } cfg_t;

  typedef struct packed {
    logic emit;
    logic border;
    logic frame_end;
  } item_tag_t;

endpackage

`default_nettype wire

/* rtl/rcb_in_if.sv */
// Input pixel channel: valid/ready handshake with action and RGB payload.
// Depends on rcb_pkg.
`default_nettype none

interface rcb_in_if;
  import rcb_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [CHAN_W-1:0] in_red;
  logic [CHAN_W-1:0] in_green;
  logic [CHAN_W-1:0] in_blue;

  modport source (output valid, action, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, action, in_red, in_green, in_blue, output ready);
endinterface

`default_nettype wire

/* rtl/rcb_out_if.sv */
// Output pixel channel: valid/ready handshake with RGB payload and frame end flag.
// Depends on rcb_pkg.
`default_nettype none

interface rcb_out_if;
  import rcb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic              frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/rcb_regs.sv */
// APB configuration registers: frame size and the three kernel rows.
// Depends on rcb_pkg.
`default_nettype none

module rcb_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rcb_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rcb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rcb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output rcb_pkg::cfg_t                   cfg,
  output logic                            dim_write
);
  import rcb_pkg::*;

  logic       wr;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_index_t'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);

  // frame size changes force the output position to be recomputed
  assign dim_write = wr && (idx == REG_IMAGE_COLS || idx == REG_IMAGE_ROWS);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_cols <= IMAGE_COLS_RESET;
      cfg.image_rows <= IMAGE_ROWS_RESET;
      cfg.kernel[0]  <= KERNEL_RESET;
      cfg.kernel[1]  <= KERNEL_RESET;
      cfg.kernel[2]  <= KERNEL_RESET;
    end else if (wr) begin
      case (idx)
        REG_IMAGE_COLS:    cfg.image_cols <= pwdata[COLS_CFG_W-1:0];
        REG_IMAGE_ROWS:    cfg.image_rows <= pwdata[ROWS_W-1:0];
        REG_KERNEL_TOP:    cfg.kernel[0]  <= pwdata[KERNEL_W-1:0];
        REG_KERNEL_MIDDLE: cfg.kernel[1]  <= pwdata[KERNEL_W-1:0];
        REG_KERNEL_BOTTOM: cfg.kernel[2]  <= pwdata[KERNEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_COLS:    prdata = APB_DATA_W'(cfg.image_cols);
      REG_IMAGE_ROWS:    prdata = APB_DATA_W'(cfg.image_rows);
      REG_KERNEL_TOP:    prdata = APB_DATA_W'(cfg.kernel[0]);
      REG_KERNEL_MIDDLE: prdata = APB_DATA_W'(cfg.kernel[1]);
      REG_KERNEL_BOTTOM: prdata = APB_DATA_W'(cfg.kernel[2]);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/rcb_ctrl.sv */
// Raster position counters, output position tracking and border/frame end tags.
// A small sequencer recomputes the output row and column after reset and after a frame size write.
// Depends on rcb_pkg.
`default_nettype none

module rcb_ctrl #(
  parameter int MAX_COLS = rcb_pkg::MAX_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rcb_pkg::cfg_t                 cfg,
  input  logic                          dim_write,
  input  logic                          accept,
  output logic                          ready,
  output rcb_pkg::item_tag_t            tag,
  output logic [$clog2(MAX_COLS)-1:0]   col
);
  import rcb_pkg::*;

  localparam int ADDR_W = $clog2(MAX_COLS);
  localparam int COLS_W = $clog2(MAX_COLS + 1);
  localparam int PROD_W = ROWS_W + COLS_W;
  localparam int CMP_W  = (PROD_W > CNT_W) ? PROD_W : CNT_W;
  localparam int STEP_W = $clog2(CNT_W);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } recalc_state_t;

  recalc_state_t state;

  logic [COLS_W-1:0] cols;
  logic [ROWS_W-1:0] rows;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] last;

  logic [ADDR_W-1:0] in_col;
  logic [ROWS_W-1:0] in_row;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  orow;
  logic [ADDR_W-1:0] ocol;

  logic [COLS_W-1:0] rem;
  logic [CNT_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic [COLS_W:0]   rem_sh;
  logic              rem_ge;

  logic              emit;
  logic              col_wrap;
  logic              fend;
  logic              border;
  logic [CNT_W-1:0]  count_inc;
  logic              ocol_wrap;

  // clamp the frame size registers to the supported range
  always_comb begin
    if (cfg.image_cols < COLS_CFG_W'(3)) begin
      cols = COLS_W'(3);
    end else if (32'(cfg.image_cols) > 32'(MAX_COLS)) begin
      cols = COLS_W'(MAX_COLS);
    end else begin
      cols = COLS_W'(cfg.image_cols);
    end
    rows = (cfg.image_rows < ROWS_W'(3)) ? ROWS_W'(3) : cfg.image_rows;
  end

  assign prod = PROD_W'(rows) * PROD_W'(cols);

  always_ff @(posedge clk) begin
    last <= prod - PROD_W'(1);
  end

  assign emit      = (in_row >= ROWS_W'(2)) || (in_row == ROWS_W'(1) && in_col != '0);
  assign col_wrap  = (COLS_W'(in_col) + COLS_W'(1)) >= cols;
  assign fend      = CMP_W'(count) >= CMP_W'(last);
  assign border    = (orow == '0) || (orow >= CNT_W'(rows - ROWS_W'(1))) ||
                     (ocol == '0) || (COLS_W'(ocol) == cols - COLS_W'(1));
  assign count_inc = count + CNT_W'(1);
  assign ocol_wrap = (COLS_W'(ocol) + COLS_W'(1)) == cols;

  assign tag.emit      = emit;
  assign tag.border    = border;
  assign tag.frame_end = fend;
  assign col           = in_col;
  assign ready         = (state == ST_IDLE);

  // one restoring division step: remainder gets the next dividend bit
  assign rem_sh = {rem, quo[CNT_W-1]};
  assign rem_ge = rem_sh >= (COLS_W + 1)'(cols);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else if (dim_write) begin
      state <= ST_LOAD;
    end else begin
      case (state)
        ST_IDLE: state <= ST_IDLE;
        ST_LOAD: state <= ST_DIV;
        ST_DIV:  state <= (step == STEP_W'(CNT_W - 1)) ? ST_DONE : ST_DIV;
        ST_DONE: state <= ST_IDLE;
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        rem  <= '0;
        quo  <= count;
        step <= '0;
      end
      ST_DIV: begin
        rem  <= rem_ge ? COLS_W'(rem_sh - (COLS_W + 1)'(cols)) : rem_sh[COLS_W-1:0];
        quo  <= {quo[CNT_W-2:0], rem_ge};
        step <= step + STEP_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col <= '0;
      in_row <= '0;
      count  <= '0;
      orow   <= '0;
      ocol   <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        in_col <= '0;
        if (in_row < rows) begin
          in_row <= in_row + ROWS_W'(1);
        end
      end else begin
        in_col <= in_col + ADDR_W'(1);
      end
      if (emit) begin
        if (fend) begin
          in_col <= '0;
          in_row <= '0;
          count  <= '0;
          orow   <= '0;
          ocol   <= '0;
        end else begin
          count <= count_inc;
          if (count_inc == '0) begin
            orow <= '0;
            ocol <= '0;
          end else if (ocol_wrap) begin
            orow <= orow + CNT_W'(1);
            ocol <= '0;
          end else begin
            ocol <= ocol + ADDR_W'(1);
          end
        end
      end
    end else if (state == ST_DONE) begin
      orow <= quo;
      ocol <= ADDR_W'(rem);
    end
  end

endmodule

`default_nettype wire

/* rtl/rcb_window.sv */
// Two line buffer memories and the 3x3 window shift register.
// Carries the item tag alongside the window update. Depends on rcb_pkg.
`default_nettype none

module rcb_window #(
  parameter int MAX_COLS = rcb_pkg::MAX_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          accept,
  input  rcb_pkg::pixel_t               pix,
  input  rcb_pkg::item_tag_t            tag,
  input  logic [$clog2(MAX_COLS)-1:0]   col,
  output rcb_pkg::window_t              win,
  output logic                          s2_valid,
  output rcb_pkg::item_tag_t            s2_tag
);
  import rcb_pkg::*;

  localparam int ADDR_W = $clog2(MAX_COLS);

  pixel_t line_one [MAX_COLS];
  pixel_t line_two [MAX_COLS];
  pixel_t rd_one;
  pixel_t rd_two;

  logic              s1_valid;
  pixel_t            s1_pix;
  logic [ADDR_W-1:0] s1_col;
  item_tag_t         s1_tag;
  logic              s1_move;

  assign s1_move = adv && s1_valid;

  // read on transfer, write back when the item leaves the first stage
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_one <= line_one[col];
    end
    if (s1_move) begin
      line_one[s1_col] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_two <= line_two[col];
    end
    if (s1_move) begin
      line_two[s1_col] <= rd_one;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid && s1_tag.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pix;
      s1_col <= col;
      s1_tag <= tag;
    end
    if (adv) begin
      s2_tag <= s1_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_move) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd_two;
      win[1][2] <= rd_one;
      win[2][2] <= s1_pix;
    end
  end

endmodule

`default_nettype wire

/* rtl/rcb_filter.sv */
// Weighted 3x3 sum per channel: products, row sums, total with saturation.
// Drives the output register and the pipeline advance. Depends on rcb_pkg.
`default_nettype none

module rcb_filter #(
  parameter int COEF_FRAC_BITS = rcb_pkg::COEF_FRAC_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rcb_pkg::cfg_t        cfg,
  input  rcb_pkg::window_t     win,
  input  logic                 s2_valid,
  input  rcb_pkg::item_tag_t   s2_tag,
  output logic                 adv,
  rcb_out_if.source            pix_out
);
  import rcb_pkg::*;

  localparam int PROD_W = COEF_W + CHAN_W;
  localparam int RSUM_W = PROD_W + 2;
  localparam int ACC_W  = PROD_W + 4;

  logic [PROD_W-1:0] prod [3][3][3];
  logic [RSUM_W-1:0] rsum [3][3];
  logic              s3_valid, s4_valid;
  item_tag_t         s3_tag, s4_tag;
  pixel_t            s3_center, s4_center;
  pixel_t            filt;

  logic              out_valid;
  pixel_t            out_pix;
  logic              out_fend;

  function automatic logic [CHAN_W-1:0] saturate(input logic [ACC_W-1:0] acc);
    if (acc[ACC_W-1:COEF_FRAC_BITS+CHAN_W] != '0) begin
      return '1;
    end
    return acc[COEF_FRAC_BITS+CHAN_W-1:COEF_FRAC_BITS];
  endfunction

  assign adv = !out_valid || pix_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            prod[ch][r][c] <= PROD_W'(cfg.kernel[r][COEF_W*c +: COEF_W]) *
                              PROD_W'(win[r][c][CHAN_W*ch +: CHAN_W]);
          end
          rsum[ch][r] <= RSUM_W'(prod[ch][r][0]) + RSUM_W'(prod[ch][r][1]) +
                         RSUM_W'(prod[ch][r][2]);
        end
      end
      s3_tag    <= s2_tag;
      s3_center <= win[1][1];
      s4_tag    <= s3_tag;
      s4_center <= s3_center;
    end
  end

  always_comb begin
    logic [ACC_W-1:0] total;
    total = '0;
    filt  = '0;
    for (int ch = 0; ch < 3; ch++) begin
      total = ACC_W'(rsum[ch][0]) + ACC_W'(rsum[ch][1]) + ACC_W'(rsum[ch][2]);
      filt[CHAN_W*ch +: CHAN_W] = saturate(total);
    end
  end

  // border pixels pass the window centre unchanged
  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix  <= s4_tag.border ? s4_center : filt;
      out_fend <= s4_tag.frame_end;
    end
  end

  assign pix_out.valid     = out_valid;
  assign pix_out.out_red   = out_pix[CHAN_W-1:0];
  assign pix_out.out_green = out_pix[2*CHAN_W-1:CHAN_W];
  assign pix_out.out_blue  = out_pix[3*CHAN_W-1:2*CHAN_W];
  assign pix_out.frame_end = out_fend;

endmodule

`default_nettype wire

/* rtl/rgb_3x3_convolution_blur.sv */
// Streaming 3x3 convolution blur for RGB888 frames in raster order. One pixel or
// drain item is taken per clock while the output is not held back and the divider
// is idle; each output pixel leaves one row plus one pixel after its input, then
// five register stages later (line buffer read, window update, products, row sums,
// output register). Interior pixels get the per channel weighted sum with unsigned
// Q4.12 weights, truncated and saturated to 255; border rows and columns pass
// unchanged. After the last pixel of a frame, image_cols+1 drain items flush the
// remaining output. A write to image_cols or image_rows, and reset, holds the input
// off while a bit-serial divider rebuilds the output row and column from the output
// count. Depends on rcb_pkg, rcb_in_if, rcb_out_if and the rcb_* submodules.
`default_nettype none

module rgb_3x3_convolution_blur #(
  parameter int MAX_COLS       = rcb_pkg::MAX_COLS_DEF,
  parameter int COEF_FRAC_BITS = rcb_pkg::COEF_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  rcb_in_if.sink                          pix_in,
  rcb_out_if.source                       pix_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rcb_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rcb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rcb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import rcb_pkg::*;

  localparam int ADDR_W = $clog2(MAX_COLS);

  cfg_t              cfg;
  logic              dim_write;
  logic              ctrl_ready;
  logic              adv;
  logic              accept;
  item_tag_t         tag;
  logic [ADDR_W-1:0] col;
  pixel_t            pix;
  window_t           win;
  logic              s2_valid;
  item_tag_t         s2_tag;

  assign pix_in.ready = adv && ctrl_ready;
  assign accept       = pix_in.valid && pix_in.ready;
  // a drain item enters as a black pixel
  assign pix = pix_in.action ? '0 : {pix_in.in_blue, pix_in.in_green, pix_in.in_red};

  rcb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .dim_write (dim_write)
  );

  rcb_ctrl #(
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .dim_write (dim_write),
    .accept    (accept),
    .ready     (ctrl_ready),
    .tag       (tag),
    .col       (col)
  );

  rcb_window #(
    .MAX_COLS (MAX_COLS)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .accept   (accept),
    .pix      (pix),
    .tag      (tag),
    .col      (col),
    .win      (win),
    .s2_valid (s2_valid),
    .s2_tag   (s2_tag)
  );

  rcb_filter #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_filter (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .win      (win),
    .s2_valid (s2_valid),
    .s2_tag   (s2_tag),
    .adv      (adv),
    .pix_out  (pix_out)
  );

endmodule

`default_nettype wire

/* bench/rgb_3x3_convolution_blur_tb.sv */
// Testbench for rgb_3x3_convolution_blur: frames of pixels and drain steps go in through
// the input channel, a line-buffer model predicts every output pixel and frame end flag.
// Depends on rcb_pkg, rcb_in_if, rcb_out_if and the block itself.
`timescale 1ns / 100ps

module rgb_3x3_convolution_blur_tb;
  import rcb_pkg::*;

  localparam int          LINE_DEPTH    = MAX_COLS_DEF;
  localparam int          FRAC_BITS     = COEF_FRAC_DEF;
  localparam int unsigned RANDOM_ITEMS  = 1700;
  localparam int          SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam logic        ACT_PIXEL     = 1'b0;
  localparam logic        ACT_DRAIN     = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              frame_end;
  } blur_pixel_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rcb_in_if  pix_in_bus ();
  rcb_out_if pix_out_bus ();

  rgb_3x3_convolution_blur uut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in_bus),
    .pix_out (pix_out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // line buffers, window and position counters of the blur model
  pixel_t                row_above     [LINE_DEPTH];
  pixel_t                row_two_above [LINE_DEPTH];
  pixel_t                nbhd          [3][3];
  int unsigned           px_col;
  int unsigned           px_row;
  int unsigned           out_count;
  logic [COLS_CFG_W-1:0] cfg_cols;
  logic [ROWS_W-1:0]     cfg_rows;
  logic [KERNEL_W-1:0]   cfg_kernel [3];

  blur_pixel_t expected_px [$];
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          steady;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned width_used();
    if (cfg_cols < 3) return 3;
    if (cfg_cols > LINE_DEPTH) return LINE_DEPTH;
    return cfg_cols;
  endfunction

  function automatic int unsigned height_used();
    return (cfg_rows < 3) ? 3 : cfg_rows;
  endfunction

  function automatic logic [CHAN_W-1:0] weighted_channel(input int lsb);
    logic [63:0]       acc;
    logic [COEF_W-1:0] wt;
    acc = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        wt  = cfg_kernel[r][COEF_W*c +: COEF_W];
        acc = acc + 64'(wt) * 64'(nbhd[r][c][lsb +: CHAN_W]);
      end
    end
    acc = acc >> FRAC_BITS;
    return (acc > 255) ? 8'hFF : acc[CHAN_W-1:0];
  endfunction

  // Advance the model by one accepted item and queue the output pixel it releases, if any.
  task automatic predict_blur(input logic act, input pixel_t px);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned orow;
    int unsigned ocol;
    logic        emit;
    logic        border;
    blur_pixel_t res;
    w   = width_used();
    h   = height_used();
    col = px_col % LINE_DEPTH;
    if (act == ACT_DRAIN) px = '0;
    emit = (px_row >= 2) || (px_row == 1 && px_col >= 1);
    for (int r = 0; r < 3; r++) begin
      nbhd[r][0] = nbhd[r][1];
      nbhd[r][1] = nbhd[r][2];
    end
    nbhd[0][2]         = row_two_above[col];
    nbhd[1][2]         = row_above[col];
    nbhd[2][2]         = px;
    row_two_above[col] = row_above[col];
    row_above[col]     = px;
    if (px_col + 1 >= w) begin
      px_col = 0;
      if (px_row < h) px_row++;
    end else begin
      px_col++;
    end
    if (emit) begin
      orow          = out_count / w;
      ocol          = out_count % w;
      border        = (orow == 0) || (orow >= h - 1) || (ocol == 0) || (ocol == w - 1);
      res.frame_end = (out_count >= h * w - 1);
      if (border) begin
        {res.blue, res.green, res.red} = nbhd[1][1];
      end else begin
        res.red   = weighted_channel(0);
        res.green = weighted_channel(CHAN_W);
        res.blue  = weighted_channel(2 * CHAN_W);
      end
      expected_px.push_back(res);
      if (res.frame_end) begin
        px_col    = 0;
        px_row    = 0;
        out_count = 0;
      end else begin
        out_count = (out_count + 1) % (1 << CNT_W);
      end
    end
  endtask

  task automatic send_pixel(input logic act, input pixel_t px);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    predict_blur(act, px);
    if (gap != 0) begin
      pix_in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in_bus.valid    <= 1'b1;
    pix_in_bus.action   <= act;
    pix_in_bus.in_red   <= px[7:0];
    pix_in_bus.in_green <= px[15:8];
    pix_in_bus.in_blue  <= px[23:16];
    do @(posedge clk); while (!pix_in_bus.ready);
    items_sent++;
  endtask

  // Drop valid and wait until the pipeline holds nothing, not even a silent item.
  task automatic settle_block();
    pix_in_bus.valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_IMAGE_COLS:    cfg_cols      = value[COLS_CFG_W-1:0];
      REG_IMAGE_ROWS:    cfg_rows      = value[ROWS_W-1:0];
      REG_KERNEL_TOP:    cfg_kernel[0] = value[KERNEL_W-1:0];
      REG_KERNEL_MIDDLE: cfg_kernel[1] = value[KERNEL_W-1:0];
      REG_KERNEL_BOTTOM: cfg_kernel[2] = value[KERNEL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_kernels(input logic [KERNEL_W-1:0] top, mid, bot);
    write_reg(REG_KERNEL_TOP, top);
    write_reg(REG_KERNEL_MIDDLE, mid);
    write_reg(REG_KERNEL_BOTTOM, bot);
  endtask

  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic pixel_t pattern_pixel(input int unsigned k);
    case (k % 4)
      0:       return 24'hFFFFFF;
      1:       return 24'h000000;
      2:       return 24'h000001 << (k % PIX_W);
      default: return 24'h7F80FE;
    endcase
  endfunction

  function automatic logic [KERNEL_W-1:0] random_kernel();
    logic [KERNEL_W-1:0] k;
    k = '0;
    case ($urandom_range(0, 3))
      0: k = {16'($urandom), $urandom};
      1: for (int c = 0; c < 3; c++) k[COEF_W*c +: COEF_W] = $urandom_range(0, 1023);
      2: for (int c = 0; c < 3; c++) k[COEF_W*c +: COEF_W] = $urandom_range(0, 65535);
      default: for (int c = 0; c < 3; c++) k[COEF_W*c +: COEF_W] = $urandom_range(300, 600);
    endcase
    return k;
  endfunction

  // Feed items until the model is back at the start of a frame; percentages give the
  // share of drain steps inside the frame and of pixels during the drain.
  task automatic run_frame(input int frame_noise, input int drain_noise, input bit patterned);
    logic        act;
    int unsigned k;
    k = 0;
    do begin
      if (px_row < height_used())
        act = ($urandom_range(0, 99) < frame_noise) ? ACT_DRAIN : ACT_PIXEL;
      else
        act = ($urandom_range(0, 99) < drain_noise) ? ACT_PIXEL : ACT_DRAIN;
      send_pixel(act, patterned ? pattern_pixel(k) : {rand_chan(), rand_chan(), rand_chan()});
      k++;
    end while (px_row != 0 || px_col != 0 || out_count != 0);
  endtask

  // Reset kernels and reset width; rows written below the floor count as three.
  task automatic check_default_width();
    steady = 1'b1;
    write_reg(REG_IMAGE_ROWS, 0);
    run_frame(0, 0, 0);
    settle_block();
  endtask

  task automatic check_full_width();
    steady = 1'b1;
    write_reg(REG_IMAGE_COLS, 2047);
    write_reg(REG_IMAGE_ROWS, 3);
    run_frame(0, 0, 0);
    settle_block();
    steady = 1'b0;
  endtask

  task automatic check_kernel_extremes();
    write_reg(REG_IMAGE_COLS, 4);
    write_reg(REG_IMAGE_ROWS, 3);
    write_kernels('1, '1, '1);
    run_frame(0, 0, 1);
    settle_block();
    write_kernels('0, '0, '0);
    run_frame(0, 0, 1);
    settle_block();
    // centre tap only: interior equals its input
    write_kernels('0, 48'h0000_1000_0000, '0);
    run_frame(0, 0, 1);
    settle_block();
    // corner taps only, to catch a swapped row or column
    write_kernels(48'h0000_0000_1000, '0, 48'h0800_0000_0000);
    run_frame(0, 0, 0);
    settle_block();
  endtask

  task automatic check_narrow_widths();
    write_kernels(KERNEL_RESET, KERNEL_RESET, KERNEL_RESET);
    write_reg(REG_IMAGE_COLS, 0);
    write_reg(REG_IMAGE_ROWS, 2);
    run_frame(0, 0, 1);
    settle_block();
    write_reg(REG_IMAGE_COLS, 2);
    write_reg(REG_IMAGE_ROWS, 4);
    run_frame(0, 0, 0);
    settle_block();
  endtask

  task automatic check_drain_inside_frame();
    write_reg(REG_IMAGE_COLS, 6);
    write_reg(REG_IMAGE_ROWS, 4);
    run_frame(25, 0, 0);
    settle_block();
  endtask

  task automatic check_pixels_during_drain();
    run_frame(0, 100, 0);
    settle_block();
  endtask

  // Start a frame of the maximum height, then cut it short once the output count
  // is already past the end of the smaller frame.
  task automatic check_rows_cut_short();
    write_reg(REG_IMAGE_COLS, 3);
    write_reg(REG_IMAGE_ROWS, 65535);
    for (int k = 0; k < 18; k++) send_pixel(ACT_PIXEL, {rand_chan(), rand_chan(), rand_chan()});
    settle_block();
    write_reg(REG_IMAGE_ROWS, 3);
    run_frame(0, 0, 0);
    settle_block();
  endtask

  task automatic check_width_change_mid_frame();
    write_reg(REG_IMAGE_COLS, 8);
    write_reg(REG_IMAGE_ROWS, 4);
    run_frame(0, 0, 0);
    settle_block();
    write_reg(REG_IMAGE_ROWS, 6);
    for (int k = 0; k < 20; k++) send_pixel(ACT_PIXEL, {rand_chan(), rand_chan(), rand_chan()});
    settle_block();
    // column counter sits on the last column of the new row and must wrap
    write_reg(REG_IMAGE_COLS, 5);
    run_frame(0, 0, 0);
    settle_block();
  endtask

  task automatic check_random_frames();
    int unsigned start;
    bit          noisy;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      settle_block();
      steady = ($urandom_range(0, 5) == 0);
      noisy  = ($urandom_range(0, 3) == 0);
      write_reg(REG_IMAGE_COLS, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
                                                             : $urandom_range(3, 12));
      write_reg(REG_IMAGE_ROWS, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                             : $urandom_range(3, 6));
      write_kernels(random_kernel(), random_kernel(), random_kernel());
      run_frame(noisy ? 8 : 0, noisy ? 40 : 0, 0);
    end
    steady = 1'b0;
  endtask

  initial begin : result_checker
    int unsigned stall;
    blur_pixel_t want;
    blur_pixel_t got;
    pix_out_bus.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        pix_out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix_out_bus.ready <= 1'b1;
      do @(posedge clk); while (!pix_out_bus.valid);
      got.red       = pix_out_bus.out_red;
      got.green     = pix_out_bus.out_green;
      got.blue      = pix_out_bus.out_blue;
      got.frame_end = pix_out_bus.frame_end;
      results_seen++;
      if (expected_px.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %0d with none pending: r=%02h g=%02h b=%02h end=%0b",
                   results_seen, got.red, got.green, got.blue, got.frame_end);
      end else begin
        want = expected_px.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.frame_end !== want.frame_end) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: expected r=%02h g=%02h b=%02h end=%0b, got r=%02h g=%02h b=%02h end=%0b",
                     results_seen, want.red, want.green, want.blue, want.frame_end,
                     got.red, got.green, got.blue, got.frame_end);
        end
      end
    end
  end

  initial begin
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    pix_in_bus.valid    <= 1'b0;
    pix_in_bus.action   <= ACT_PIXEL;
    pix_in_bus.in_red   <= '0;
    pix_in_bus.in_green <= '0;
    pix_in_bus.in_blue  <= '0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      row_above[i]     = '0;
      row_two_above[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) nbhd[r][c] = '0;
    px_col        = 0;
    px_row        = 0;
    out_count     = 0;
    cfg_cols      = IMAGE_COLS_RESET;
    cfg_rows      = IMAGE_ROWS_RESET;
    cfg_kernel[0] = KERNEL_RESET;
    cfg_kernel[1] = KERNEL_RESET;
    cfg_kernel[2] = KERNEL_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    check_default_width();
    check_full_width();
    check_kernel_extremes();
    check_narrow_widths();
    check_drain_inside_frame();
    check_pixels_during_drain();
    check_rows_cut_short();
    check_width_change_mid_frame();
    check_random_frames();

    settle_block();
    if (fail_count == 0 && expected_px.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
